[src/mf3x3_pkg.sv]
// Package for the 3x3 median filter: pixel and column types, register
// indexes, line store word layout and the small compare/select functions.
// No dependencies.
package mf3x3_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 13;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Source of one column entry: older line, newer line or incoming pixel.
  localparam logic [1:0] SEL_UPPER = 2'd0;
  localparam logic [1:0] SEL_LOWER = 2'd1;
  localparam logic [1:0] SEL_PIXEL = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // A window column, kept sorted.
  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } col_t;

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } ls_word_t;

  typedef struct packed {
    col_t [2:0] cols;
    logic       last;
  } med_req_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(pix_t a, pix_t b, pix_t c);
    col_t res;
    pix_t lo1;
    pix_t hi1;
    pix_t t;
    lo1     = min2(a, b);
    hi1     = max2(a, b);
    res.hi  = max2(hi1, c);
    t       = min2(hi1, c);
    res.lo  = min2(lo1, t);
    res.mid = max2(lo1, t);
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(logic [CFG_W-1:0] v);
    if (v == '0) begin
      return ROW_W'(1);
    end
    if (v > CFG_W'(MAX_HEIGHT)) begin
      return ROW_W'(MAX_HEIGHT);
    end
    return ROW_W'(v);
  endfunction

endpackage

[src/mf3x3_line_store.sv]
// Line store of the 3x3 median filter: one synchronous memory holding the
// two previous rows side by side, one read and one write port.
// Depends on mf3x3_pkg.
module mf3x3_line_store #(
  parameter int MAX_WIDTH = mf3x3_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output mf3x3_pkg::ls_word_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  mf3x3_pkg::ls_word_t wr_data
);
  import mf3x3_pkg::*;

  ls_word_t mem [MAX_WIDTH];
  ls_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/mf3x3_median.sv]
// Median stages of the 3x3 median filter: combines three sorted columns
// into the median of nine over two register stages plus the output register.
// Depends on mf3x3_pkg.
module mf3x3_median (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  mf3x3_pkg::med_req_t req,
  output logic                res_valid,
  input  logic                res_ready,
  output mf3x3_pkg::pix_t     res_pixel,
  output logic                res_last
);
  import mf3x3_pkg::*;

  logic     s2_v_r;
  med_req_t s2_r;
  logic     s3_v_r;
  pix_t     s3_lo_r;
  pix_t     s3_mid_r;
  pix_t     s3_hi_r;
  logic     s3_last_r;
  logic     o_v_r;
  pix_t     o_pix_r;
  logic     o_last_r;

  logic o_free;
  logic s3_free;
  logic s2_free;
  logic s3_go;
  logic s2_go;

  assign o_free    = !o_v_r || res_ready;
  assign s3_free   = !s3_v_r || o_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign s3_go     = s3_v_r && o_free;
  assign s2_go     = s2_v_r && s3_free;
  assign req_ready = s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= req_valid;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (o_free) begin
        o_v_r <= s3_v_r;
      end
    end
  end

  // Max of the column minima, median of the medians, min of the maxima;
  // the median of those three is the median of all nine.
  always_ff @(posedge clk) begin
    if (s2_free && req_valid) begin
      s2_r <= req;
    end
    if (s2_go) begin
      s3_lo_r   <= max2(max2(s2_r.cols[0].lo, s2_r.cols[1].lo), s2_r.cols[2].lo);
      s3_mid_r  <= med3(s2_r.cols[0].mid, s2_r.cols[1].mid, s2_r.cols[2].mid);
      s3_hi_r   <= min2(min2(s2_r.cols[0].hi, s2_r.cols[1].hi), s2_r.cols[2].hi);
      s3_last_r <= s2_r.last;
    end
    if (s3_go) begin
      o_pix_r  <= med3(s3_lo_r, s3_mid_r, s3_hi_r);
      o_last_r <= s3_last_r;
    end
  end

  assign res_valid = o_v_r;
  assign res_pixel = o_pix_r;
  assign res_last  = o_last_r;

endmodule

[src/median_filter_3x3.sv]
// 3x3 median filter, top level. Takes one pixel or flush request per cycle
// when the output is not stalled; the request that causes a result passes
// the line store read, the window stage and two median stages.
// Results start one row plus one pixel behind the pixel stream.
// Reset (synchronous, active low) clears counters, window and valid bits and
// restores the default size; the line store is not cleared.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = mf3x3_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_pixel_in,
  input  logic                               in_flush,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_pixel_out,
  output logic                               out_frame_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mf3x3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mf3x3_pkg::CFG_W-1:0]        cfg_wdata
);
  import mf3x3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic       emit;
    logic       last;
    logic       wr;
    logic       first_col;
    logic       second_col;
    logic       wide;
    logic [1:0] sel0;
    logic [1:0] sel1;
    logic [1:0] sel2;
  } s1_ctrl_t;

  function automatic logic [WW-1:0] clamp_w(logic [CFG_W-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end
    if (32'(v) > 32'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  logic [WW-1:0]    eff_w_r;
  logic [ROW_W-1:0] eff_h_r;
  logic [AW-1:0]    in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [AW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [WW-1:0]    col_inc;

  logic     s1_v_r;
  s1_ctrl_t s1_ctrl_r;
  s1_ctrl_t ctrl_nxt;
  pix_t     s1_pix_r;
  logic [AW-1:0] s1_col_r;
  logic     fwd_r;
  ls_word_t fwd_word_r;
  col_t     win_r [3];

  logic row_lt_h;
  logic r0;
  logic r1;
  logic rh;
  logic rh1;
  logic drop;
  logic take;
  logic s1_ready;
  logic s1_go;

  ls_word_t rd_word;
  ls_word_t cur;
  ls_word_t wr_word;
  logic     wr_en;
  pix_t     colv [3];
  col_t     new_col;
  med_req_t med_req;
  logic     med_valid;
  logic     med_ready;

  assign row_lt_h = in_row_r < eff_h_r;
  assign r0       = in_row_r == '0;
  assign r1       = in_row_r == ROW_W'(1);
  assign rh       = in_row_r == eff_h_r;
  assign rh1      = in_row_r == (eff_h_r + ROW_W'(1));
  assign drop     = row_lt_h && in_flush;

  assign s1_go    = s1_v_r && (!s1_ctrl_r.emit || med_ready);
  assign s1_ready = !s1_v_r || s1_go;
  assign in_ready = s1_ready;
  assign take     = in_valid && s1_ready && !drop;
  assign cfg_ready = 1'b1;

  // Column vector sources for rows r-2, r-1, r clamped to the image.
  always_comb begin
    ctrl_nxt            = '0;
    ctrl_nxt.emit       = (in_row_r >= ROW_W'(2)) || (r1 && (in_col_r != '0));
    ctrl_nxt.last       = rh1;
    ctrl_nxt.wr         = row_lt_h;
    ctrl_nxt.first_col  = in_col_r == '0;
    ctrl_nxt.second_col = in_col_r == AW'(1);
    ctrl_nxt.wide       = eff_w_r >= WW'(2);
    if (r0) begin
      ctrl_nxt.sel0 = SEL_PIXEL;
    end else if (r1) begin
      ctrl_nxt.sel0 = SEL_LOWER;
    end else begin
      ctrl_nxt.sel0 = SEL_UPPER;
    end
    if (r0) begin
      ctrl_nxt.sel1 = SEL_PIXEL;
    end else if (rh1) begin
      ctrl_nxt.sel1 = SEL_UPPER;
    end else begin
      ctrl_nxt.sel1 = SEL_LOWER;
    end
    if (rh1) begin
      ctrl_nxt.sel2 = SEL_UPPER;
    end else if (rh) begin
      ctrl_nxt.sel2 = SEL_LOWER;
    end else begin
      ctrl_nxt.sel2 = SEL_PIXEL;
    end
  end

  always_comb begin
    col_inc = WW'(in_col_r) + WW'(1);
    if (rh1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= eff_w_r) begin
      col_nxt = '0;
      row_nxt = in_row_r + ROW_W'(1);
    end else begin
      col_nxt = AW'(col_inc);
      row_nxt = in_row_r;
    end
  end

  mf3x3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (s1_col_r),
    .wr_data (wr_word)
  );

  // With a one-pixel row the next request reads the entry being written now.
  assign cur           = fwd_r ? fwd_word_r : rd_word;
  assign wr_en         = s1_go && s1_ctrl_r.wr;
  assign wr_word.upper = cur.lower;
  assign wr_word.lower = s1_pix_r;

  always_comb begin
    s1_ctrl_t c;
    logic [1:0] sel [3];
    c      = s1_ctrl_r;
    sel[0] = c.sel0;
    sel[1] = c.sel1;
    sel[2] = c.sel2;
    for (int i = 0; i < 3; i++) begin
      case (sel[i])
        SEL_UPPER: colv[i] = cur.upper;
        SEL_LOWER: colv[i] = cur.lower;
        default:   colv[i] = s1_pix_r;
      endcase
    end
  end

  assign new_col = sort3(colv[0], colv[1], colv[2]);

  // Columns of the window after the shift, with left and right borders
  // replicated.
  always_comb begin
    med_req.last = s1_ctrl_r.last;
    if (s1_ctrl_r.first_col) begin
      med_req.cols[0] = s1_ctrl_r.wide ? win_r[1] : win_r[2];
      med_req.cols[1] = win_r[2];
      med_req.cols[2] = win_r[2];
    end else if (s1_ctrl_r.second_col) begin
      med_req.cols[0] = win_r[2];
      med_req.cols[1] = win_r[2];
      med_req.cols[2] = new_col;
    end else begin
      med_req.cols[0] = win_r[1];
      med_req.cols[1] = win_r[2];
      med_req.cols[2] = new_col;
    end
  end

  assign med_valid = s1_v_r && s1_ctrl_r.emit;

  mf3x3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (med_valid),
    .req_ready (med_ready),
    .req       (med_req),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_pixel (out_pixel_out),
    .res_last  (out_frame_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r  <= clamp_w(CFG_W'(WIDTH_RESET));
      eff_h_r  <= clamp_height(CFG_W'(HEIGHT_RESET));
      in_col_r <= '0;
      in_row_r <= '0;
      s1_v_r   <= 1'b0;
      fwd_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            eff_w_r  <= clamp_w(cfg_wdata);
            in_col_r <= '0;
            in_row_r <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            eff_h_r  <= clamp_height(cfg_wdata);
            in_col_r <= '0;
            in_row_r <= '0;
          end
          default: begin
          end
        endcase
      end else if (take) begin
        in_col_r <= col_nxt;
        in_row_r <= row_nxt;
      end
      if (s1_ready) begin
        s1_v_r <= take;
      end
      if (take) begin
        fwd_r <= wr_en && (s1_col_r == in_col_r);
      end
      if (s1_go) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= new_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctrl_r  <= ctrl_nxt;
      s1_pix_r   <= in_pixel_in;
      s1_col_r   <= in_col_r;
      fwd_word_r <= wr_word;
    end
  end

endmodule

[src/mf3x3_checker.sv]
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on median_filter_3x3.
module mf3x3_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_out,
  input logic       out_frame_last,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
      $stable(out_frame_last))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Whenever the output side can move, a new request is taken.
  a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output is free");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind median_filter_3x3 mf3x3_checker u_mf3x3_checker (.*);
